// ===== design/pcmrc_pkg.sv =====
// Shared types, constants and helper functions for the PCM 3:2 / 2:3 rate converter.
// No dependencies; used by every other file of the block.
package pcmrc_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int NUM_FIELDS   = 4;
	localparam int MAX_CHANNELS = 4;
	localparam int CNT_W        = 3;
	localparam int REG_IDX_W    = 2;
	localparam int MAX_RESULTS  = 3;
	localparam int ACT_LIMIT    = (MAX_CHANNELS < NUM_FIELDS) ? MAX_CHANNELS : NUM_FIELDS;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_DIRECTION     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

	// direction codes
	localparam logic DIR_DOWN = 1'b0;
	localparam logic DIR_UP   = 1'b1;

	// group phase codes; the fourth code acts as PH_FIRST
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	localparam logic [CNT_W-1:0] CH_COUNT_RESET = 3'd2;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t [NUM_FIELDS-1:0] ch;
		logic                     last;
	} result_t;

	// all results caused by one input item
	typedef struct packed {
		logic [1:0]                cnt;
		result_t [MAX_RESULTS-1:0] res;
	} group_t;

	// (a + b) / 2, truncated toward zero
	function automatic sample_t avg2(input sample_t a, input sample_t b);
		logic [SAMPLE_W:0] s;
		logic [SAMPLE_W:0] t;
		s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		t = s + {{SAMPLE_W{1'b0}}, s[SAMPLE_W]};
		return t[SAMPLE_W:1];
	endfunction

	function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] cc);
		logic [CNT_W-1:0] n;
		n = cc;
		if (n == '0) begin
			n = CNT_W'(1);
		end
		if (n > CNT_W'(ACT_LIMIT)) begin
			n = CNT_W'(ACT_LIMIT);
		end
		return n;
	endfunction

endpackage

// ===== design/pcmrc_group.sv =====
// Configuration registers, group phase and held frames; forms the result group of each item.
// Depends on pcmrc_pkg.
module pcmrc_group (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [pcmrc_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [pcmrc_pkg::CNT_W-1:0]           cfg_data,
	input  logic                                  accept,
	input  pcmrc_pkg::sample_t [pcmrc_pkg::NUM_FIELDS-1:0] cur,
	input  logic                                  buffer_end,
	output logic                                  push,
	output pcmrc_pkg::group_t                     grp
);

	logic                          direction_q;
	logic [pcmrc_pkg::CNT_W-1:0]   channel_count_q;
	logic [1:0]                    phase_q;
	pcmrc_pkg::sample_t [pcmrc_pkg::NUM_FIELDS-1:0] held_first_q;
	pcmrc_pkg::sample_t [pcmrc_pkg::NUM_FIELDS-1:0] held_second_q;

	logic [pcmrc_pkg::CNT_W-1:0]   nch;
	logic [1:0]                    phase_d;
	logic                          wr_first;
	logic                          wr_second;

	always_comb begin
		nch       = pcmrc_pkg::active_count(channel_count_q);
		grp       = '0;
		phase_d   = pcmrc_pkg::PH_SECOND;
		wr_first  = 1'b0;
		wr_second = 1'b0;
		if (direction_q == pcmrc_pkg::DIR_DOWN) begin
			case (phase_q)
				pcmrc_pkg::PH_SECOND: begin
					wr_second = 1'b1;
					phase_d   = pcmrc_pkg::PH_THIRD;
				end
				pcmrc_pkg::PH_THIRD: begin
					grp.cnt = 2'd2;
					for (int c = 0; c < pcmrc_pkg::NUM_FIELDS; c++) begin
						if (pcmrc_pkg::CNT_W'(c) < nch) begin
							grp.res[0].ch[c] = held_first_q[c];
							grp.res[1].ch[c] = pcmrc_pkg::avg2(held_second_q[c], cur[c]);
						end
					end
					grp.res[1].last = 1'b1;
					phase_d = pcmrc_pkg::PH_FIRST;
				end
				default: begin
					wr_first = 1'b1;
					phase_d  = pcmrc_pkg::PH_SECOND;
				end
			endcase
		end else begin
			if (phase_q == pcmrc_pkg::PH_SECOND) begin
				wr_second          = 1'b1;
				grp.cnt            = 2'd3;
				grp.res[0].ch[0]   = held_first_q[0];
				grp.res[1].ch[0]   = pcmrc_pkg::avg2(held_first_q[0], cur[0]);
				grp.res[2].ch[0]   = cur[0];
				grp.res[2].last    = 1'b1;
				phase_d            = pcmrc_pkg::PH_FIRST;
			end else begin
				wr_first = 1'b1;
				if (buffer_end) begin
					// lone final sample passes straight through
					grp.cnt          = 2'd1;
					grp.res[0].ch[0] = cur[0];
					grp.res[0].last  = 1'b1;
				end
				phase_d = pcmrc_pkg::PH_SECOND;
			end
		end
		if (buffer_end) begin
			phase_d = pcmrc_pkg::PH_FIRST;
		end
	end

	assign push = accept && (grp.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q     <= pcmrc_pkg::DIR_DOWN;
			channel_count_q <= pcmrc_pkg::CH_COUNT_RESET;
			phase_q         <= pcmrc_pkg::PH_FIRST;
		end else if (cfg_wr_en) begin
			// a write to the direction or channel-count register drops a group in progress
			case (cfg_index)
				pcmrc_pkg::REG_DIRECTION: begin
					direction_q <= cfg_data[0];
					phase_q     <= pcmrc_pkg::PH_FIRST;
				end
				pcmrc_pkg::REG_CHANNEL_COUNT: begin
					channel_count_q <= cfg_data;
					phase_q         <= pcmrc_pkg::PH_FIRST;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_first) begin
			held_first_q <= cur;
		end
		if (accept && wr_second) begin
			held_second_q <= cur;
		end
	end

endmodule

// ===== design/pcmrc_outq.sv =====
// Two-entry buffer of result groups; one result per cycle goes out while out_ready is high.
// Depends on pcmrc_pkg.
module pcmrc_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pcmrc_pkg::group_t  grp,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output pcmrc_pkg::result_t res
);

	pcmrc_pkg::group_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic [1:0]        idx_q;

	pcmrc_pkg::group_t head;
	logic              take;
	logic              pop;

	always_comb begin
		head      = slot_q[rd_ptr_q];
		out_valid = (count_q != 2'd0);
		res       = head.res[idx_q];
		take      = out_valid && out_ready;
		pop       = take && (idx_q == (head.cnt - 2'd1));
		space     = (count_q != 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				idx_q    <= 2'd0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= grp;
		end
	end

endmodule

// ===== design/pcm_rate_converter_3to2_2to3.sv =====
// PCM rate converter, 3:2 down (frames of up to four channels) and 2:3 up (channel 0).
// Each accepted item is turned into its results in the same cycle, and any results are
// stored as one group in a two-group buffer. With the buffer empty, the first result
// shows on the output the cycle after the item is accepted. Results leave at one per
// cycle while out_ready is high. Input is taken in every cycle while a group slot is
// free. In down mode the input port sets the rate: one item per cycle while out_ready
// is high. In up mode the output port sets it: three results per two items, and
// in_ready drops while both slots are full. Writes to the direction and channel-count
// registers take effect at once and restart the grouping phase.
// Depends on pcmrc_pkg, pcmrc_group, pcmrc_outq.
module pcm_rate_converter_3to2_2to3 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [pcmrc_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [pcmrc_pkg::CNT_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pcmrc_pkg::SAMPLE_W-1:0] sample_ch0,
	input  logic signed [pcmrc_pkg::SAMPLE_W-1:0] sample_ch1,
	input  logic signed [pcmrc_pkg::SAMPLE_W-1:0] sample_ch2,
	input  logic signed [pcmrc_pkg::SAMPLE_W-1:0] sample_ch3,
	input  logic                                buffer_end,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pcmrc_pkg::SAMPLE_W-1:0] out_ch0,
	output logic signed [pcmrc_pkg::SAMPLE_W-1:0] out_ch1,
	output logic signed [pcmrc_pkg::SAMPLE_W-1:0] out_ch2,
	output logic signed [pcmrc_pkg::SAMPLE_W-1:0] out_ch3,
	output logic                                run_last
);

	pcmrc_pkg::sample_t [pcmrc_pkg::NUM_FIELDS-1:0] cur;
	pcmrc_pkg::group_t  grp;
	pcmrc_pkg::result_t res;
	logic               push;
	logic               space;
	logic               accept;

	assign cur      = {sample_ch3, sample_ch2, sample_ch1, sample_ch0};
	assign in_ready = space;
	assign accept   = in_valid && space;

	pcmrc_group u_group (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.cur        (cur),
		.buffer_end (buffer_end),
		.push       (push),
		.grp        (grp)
	);

	pcmrc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.grp       (grp),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign out_ch0  = res.ch[0];
	assign out_ch1  = res.ch[1];
	assign out_ch2  = res.ch[2];
	assign out_ch3  = res.ch[3];
	assign run_last = res.last;

endmodule

// ===== design/pcmrc_checker.sv =====
// Port-level checks for the rate converter, bound to the top level.
// Depends on pcmrc_pkg for widths.
module pcmrc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [pcmrc_pkg::SAMPLE_W-1:0] out_ch0,
	input logic signed [pcmrc_pkg::SAMPLE_W-1:0] out_ch1,
	input logic signed [pcmrc_pkg::SAMPLE_W-1:0] out_ch2,
	input logic signed [pcmrc_pkg::SAMPLE_W-1:0] out_ch3,
	input logic                                run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_ch0) && $stable(out_ch1) &&
			$stable(out_ch2) && $stable(out_ch3) && $stable(run_last))
		else $error("result changed while stalled");

	// a full buffer always has something to deliver
	a_full_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input blocked with no result pending");

	// out_valid holds after each result of an item until its last one is taken
	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("item results cut short");

endmodule

bind pcm_rate_converter_3to2_2to3 pcmrc_checker u_chk (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for pcm_rate_converter_3to2_2to3: directed and random frame streams,
// predicted per item in the bench and compared field by field on the result port.
// Depends on pcmrc_pkg and the converter RTL.
`timescale 1ns / 100ps

module testbench;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int MAX_REPORTS   = 30;
	localparam int ITEMS_PER_RUN = 20;
	localparam int OWED_DEPTH    = 32;

	// indexes past the register list, written to check that they are ignored
	localparam logic [pcmrc_pkg::REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [pcmrc_pkg::REG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam pcmrc_pkg::sample_t SAMPLE_MAX = 16'h7FFF;
	localparam pcmrc_pkg::sample_t SAMPLE_MIN = 16'h8000;

	typedef pcmrc_pkg::sample_t [pcmrc_pkg::NUM_FIELDS-1:0] frame_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [pcmrc_pkg::REG_IDX_W-1:0] cfg_index;
	logic [pcmrc_pkg::CNT_W-1:0]     cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic signed [pcmrc_pkg::SAMPLE_W-1:0] sample_ch0, sample_ch1, sample_ch2, sample_ch3;
	logic                  buffer_end;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [pcmrc_pkg::SAMPLE_W-1:0] out_ch0, out_ch1, out_ch2, out_ch3;
	logic                  run_last;

	pcm_rate_converter_3to2_2to3 uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_ch0 (sample_ch0),
		.sample_ch1 (sample_ch1),
		.sample_ch2 (sample_ch2),
		.sample_ch3 (sample_ch3),
		.buffer_end (buffer_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_ch0    (out_ch0),
		.out_ch1    (out_ch1),
		.out_ch2    (out_ch2),
		.out_ch3    (out_ch3),
		.run_last   (run_last)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// converter state as the bench sees it
	logic                        conv_dir;
	logic [pcmrc_pkg::CNT_W-1:0] conv_count;
	logic [1:0]                  conv_phase;
	frame_t                      held_a;
	frame_t                      held_b;

	// expected results, a ring indexed by running counts
	pcmrc_pkg::result_t owed_frames[OWED_DEPTH];
	int owed_head;
	int owed_tail;

	int mismatches;
	int sender_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	function automatic pcmrc_pkg::sample_t mean_of_two(input pcmrc_pkg::sample_t a,
		input pcmrc_pkg::sample_t b);
		int x;
		int y;
		x = $signed(a);
		y = $signed(b);
		return pcmrc_pkg::sample_t'((x + y) / 2);
	endfunction

	function automatic int live_channels();
		int n;
		n = conv_count;
		if (n == 0) begin
			n = 1;
		end
		if (n > pcmrc_pkg::ACT_LIMIT) begin
			n = pcmrc_pkg::ACT_LIMIT;
		end
		return n;
	endfunction

	task automatic owe_frame(input frame_t v, input int nch, input logic last);
		pcmrc_pkg::result_t r;
		for (int c = 0; c < pcmrc_pkg::NUM_FIELDS; c++) begin
			r.ch[c] = (c < nch) ? v[c] : '0;
		end
		r.last = last;
		owed_frames[owed_tail % OWED_DEPTH] = r;
		owed_tail++;
	endtask

	task automatic convert_frame(input frame_t fr, input logic be);
		frame_t m;
		int     nch;
		m = '0;
		nch = live_channels();
		if (conv_dir == pcmrc_pkg::DIR_DOWN) begin
			if (conv_phase == pcmrc_pkg::PH_SECOND) begin
				held_b = fr;
				conv_phase = pcmrc_pkg::PH_THIRD;
			end else if (conv_phase == pcmrc_pkg::PH_THIRD) begin
				owe_frame(held_a, nch, 1'b0);
				for (int c = 0; c < pcmrc_pkg::NUM_FIELDS; c++) begin
					m[c] = mean_of_two(held_b[c], fr[c]);
				end
				owe_frame(m, nch, 1'b1);
				conv_phase = pcmrc_pkg::PH_FIRST;
			end else begin
				held_a = fr;
				conv_phase = pcmrc_pkg::PH_SECOND;
			end
		end else begin
			if (conv_phase == pcmrc_pkg::PH_SECOND) begin
				held_b = fr;
				owe_frame(held_a, 1, 1'b0);
				m[0] = mean_of_two(held_a[0], fr[0]);
				owe_frame(m, 1, 1'b0);
				owe_frame(fr, 1, 1'b1);
				conv_phase = pcmrc_pkg::PH_FIRST;
			end else begin
				held_a = fr;
				// lone final sample goes straight through
				if (be) begin
					owe_frame(fr, 1, 1'b1);
				end
				conv_phase = pcmrc_pkg::PH_SECOND;
			end
		end
		if (be) begin
			conv_phase = pcmrc_pkg::PH_FIRST;
		end
	endtask

	// valid stays up across back-to-back items; it only drops for a gap
	task automatic send_frame(input frame_t fr, input logic be);
		@(negedge clk);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		sample_ch0 = fr[0];
		sample_ch1 = fr[1];
		sample_ch2 = fr[2];
		sample_ch3 = fr[3];
		buffer_end = be;
		do @(posedge clk); while (!in_ready);
		convert_frame(fr, be);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (owed_tail != owed_head) begin
			@(posedge clk);
		end
	endtask

	// a frame with no result may still be in flight after the drain
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pcmrc_pkg::REG_IDX_W-1:0] idx,
		input logic [pcmrc_pkg::CNT_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == pcmrc_pkg::REG_DIRECTION) begin
			conv_dir   = val[0];
			conv_phase = pcmrc_pkg::PH_FIRST;
		end else if (idx == pcmrc_pkg::REG_CHANNEL_COUNT) begin
			conv_count = val;
			conv_phase = pcmrc_pkg::PH_FIRST;
		end
	endtask

	function automatic pcmrc_pkg::sample_t pick_sample();
		case ($urandom_range(7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return pcmrc_pkg::sample_t'($urandom_range(8)) - 16'd4;
			default: return pcmrc_pkg::sample_t'($urandom);
		endcase
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		for (int c = 0; c < pcmrc_pkg::NUM_FIELDS; c++) begin
			f[c] = pick_sample();
		end
		return f;
	endfunction

	// reset defaults: down mode, two channels, upper channels forced to zero
	task automatic test_reset_state();
		send_frame({16'h0123, 16'hFFFF, SAMPLE_MIN, SAMPLE_MAX}, 1'b0);
		send_frame({16'h4000, 16'h8001, 16'h0005, 16'hFFFB}, 1'b0);
		send_frame({16'hBFFF, 16'h7FFE, 16'hFFF8, 16'h0002}, 1'b0);
	endtask

	// sums at both rails, a negative odd sum that truncates toward zero
	task automatic test_down_averaging();
		settle();
		write_reg(pcmrc_pkg::REG_CHANNEL_COUNT, 3'd4);
		send_frame({16'hFFFF, 16'h0001, SAMPLE_MIN, SAMPLE_MAX}, 1'b0);
		send_frame({16'hFFFD, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX}, 1'b0);
		send_frame({16'h0000, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX}, 1'b0);
	endtask

	// buffer end after one and after two frames drops the partial group
	task automatic test_partial_groups();
		send_frame(random_frame(), 1'b1);
		send_frame(random_frame(), 1'b0);
		send_frame(random_frame(), 1'b1);
	endtask

	task automatic test_up_mode();
		settle();
		write_reg(pcmrc_pkg::REG_DIRECTION, {2'b00, pcmrc_pkg::DIR_UP});
		send_frame({16'h1111, 16'h2222, 16'hFFFF, 16'd100}, 1'b0);
		send_frame({16'h3333, 16'h4444, 16'h8000, 16'hFF9B}, 1'b0);
		send_frame({16'h5555, 16'h6666, 16'h7777, SAMPLE_MIN}, 1'b1);
		send_frame({16'hAAAA, 16'hBBBB, 16'hCCCC, SAMPLE_MIN}, 1'b0);
		send_frame({16'hDDDD, 16'hEEEE, 16'h0001, 16'h8001}, 1'b1);
	endtask

	// zero counts as one channel, anything above four saturates
	task automatic test_count_limits();
		settle();
		write_reg(pcmrc_pkg::REG_DIRECTION, {2'b11, pcmrc_pkg::DIR_DOWN});
		write_reg(pcmrc_pkg::REG_CHANNEL_COUNT, 3'd0);
		repeat (3) send_frame(random_frame(), 1'b0);
		settle();
		write_reg(pcmrc_pkg::REG_CHANNEL_COUNT, 3'd7);
		repeat (3) send_frame(random_frame(), 1'b0);
	endtask

	// a register write mid-group restarts the group; spare indexes do not
	task automatic test_write_restarts_group();
		send_frame(random_frame(), 1'b0);
		settle();
		write_reg(pcmrc_pkg::REG_DIRECTION, {2'b00, pcmrc_pkg::DIR_DOWN});
		send_frame(random_frame(), 1'b0);
		settle();
		write_reg(REG_SPARE_A, 3'd7);
		write_reg(REG_SPARE_B, 3'd1);
		send_frame(random_frame(), 1'b0);
		send_frame(random_frame(), 1'b1);
	endtask

	task automatic test_random_traffic();
		int          sent;
		int          len;
		int          grp;
		logic        paused;
		logic        dir;
		int          idle_plan[4];
		int          stall_plan[4];
		idle_plan  = '{0, 70, 0, 14};
		stall_plan = '{0, 0, 70, 14};
		for (int p = 0; p < 4; p++) begin
			settle();
			sender_idle_pct = idle_plan[p];
			recv_stall_pct  = stall_plan[p];
			dir = (p < 2) ? p[0] : 1'($urandom_range(1));
			write_reg(pcmrc_pkg::REG_DIRECTION, {2'($urandom_range(3)), dir});
			write_reg(pcmrc_pkg::REG_CHANNEL_COUNT,
				(p == 0) ? 3'd4 : 3'($urandom_range(7)));
			sent = 0;
			paused = 1'b0;
			while (sent < ITEMS_PER_RUN) begin
				grp = (conv_dir == pcmrc_pkg::DIR_UP) ? 2 : 3;
				// mostly whole groups per buffer, some ragged buffers
				if ($urandom_range(99) < 75) begin
					len = grp * $urandom_range(1, 3);
				end else begin
					len = $urandom_range(1, 7);
				end
				for (int i = 0; i < len; i++) begin
					send_frame(random_frame(), i == len - 1);
				end
				sent += len;
				if (!paused && sent >= ITEMS_PER_RUN / 2) begin
					drain();
					paused = 1'b1;
				end
			end
		end
	endtask

	always @(negedge clk) begin
		out_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		pcmrc_pkg::result_t want;
		pcmrc_pkg::result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.ch[0] = out_ch0;
			got.ch[1] = out_ch1;
			got.ch[2] = out_ch2;
			got.ch[3] = out_ch3;
			got.last  = run_last;
			if (owed_tail == owed_head) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: unexpected item, expected none got %h", $time, got);
				end
			end else begin
				want = owed_frames[owed_head % OWED_DEPTH];
				owed_head++;
				for (int c = 0; c < pcmrc_pkg::NUM_FIELDS; c++) begin
					if (got.ch[c] !== want.ch[c]) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: out_ch%0d expected %0d got %0d", $time, c,
								$signed(want.ch[c]), $signed(got.ch[c]));
						end
					end
				end
				if (got.last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: run_last expected %b got %b", $time,
							want.last, got.last);
					end
				end
			end
		end
	end

	// a missing result stalls the final drain and ends up here
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_index       = pcmrc_pkg::REG_DIRECTION;
		cfg_data        = '0;
		in_valid        = 1'b0;
		sample_ch0      = '0;
		sample_ch1      = '0;
		sample_ch2      = '0;
		sample_ch3      = '0;
		buffer_end      = 1'b0;
		out_ready       = 1'b0;
		owed_head       = 0;
		owed_tail       = 0;
		mismatches      = 0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		quiet_cycles    = 0;
		conv_dir        = pcmrc_pkg::DIR_DOWN;
		conv_count      = pcmrc_pkg::CH_COUNT_RESET;
		conv_phase      = pcmrc_pkg::PH_FIRST;
		held_a          = '0;
		held_b          = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_down_averaging();
		test_partial_groups();
		test_up_mode();
		test_count_limits();
		test_write_restarts_group();
		test_random_traffic();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
